// File: src/first_fit_region_allocator_unit_defines.svh
// assertion macros for the first-fit region allocator
// used by modules that check their own sequencing; needs clk and rst in scope
`ifndef FIRST_FIT_REGION_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_REGION_ALLOCATOR_UNIT_DEFINES_SVH

// property that holds at every edge out of reset
`define FFRA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("ffra: invariant violated");

// same-cycle implication
`define FFRA_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ffra: implication violated");

// next-cycle implication
`define FFRA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ffra: next-cycle implication violated");

`endif

// File: src/ffra_pkg.sv
// shared types, codes and sizes of the first-fit region allocator
// no dependencies
`default_nettype none

package ffra_pkg;

  localparam int ADDR_BITS   = 48;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef struct packed {
    addr_t start;
    addr_t length;
  } region_t;

  typedef struct packed {
    addr_t a;
    addr_t b;
    logic  sub;
  } alu_req_t;

  typedef struct packed {
    addr_t sum;
    logic  carry;
    logic  zero;
  } alu_res_t;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_DFREE   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_AUTOGROW   = 1'b0,
    CFG_INIT_BYTES = 1'b1
  } cfg_t;

  typedef enum logic [1:0] {
    CTX_FREE  = 2'd0,
    CTX_GROW  = 2'd1,
    CTX_ALLOC = 2'd2
  } ctx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_A_START, S_GROW_START, S_AR_START, S_AR_RD, S_AR_CK, S_AR_P1,
    S_AR_P2, S_AR_S1, S_AR_F, S_AR_MP, S_AR_MB, S_AR_MS, S_INS_RD, S_INS_WR,
    S_DROP_RD, S_DROP_WR, S_AR_OK, S_AR_RET, S_FF_RD, S_FF_CK, S_FF_SP1,
    S_FF_SP2, S_A_FREE, S_Z_RD, S_Z_CK, S_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: src/ffra_ram.sv
// region table storage: one write port, one registered read port
// generic, no package dependency
`default_nettype none

module ffra_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: src/ffra_alu.sv
// shared add/subtract and compare unit
// depends on ffra_pkg
`default_nettype none

module ffra_alu (
  input  wire ffra_pkg::alu_req_t req,
  output ffra_pkg::alu_res_t      res
);

  logic [ffra_pkg::ADDR_BITS:0] total;

  // subtract as a + ~b + 1: carry set means a >= b
  always_comb begin
    total = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
          + {{ffra_pkg::ADDR_BITS{1'b0}}, req.sub};
    res.sum   = total[ffra_pkg::ADDR_BITS-1:0];
    res.carry = total[ffra_pkg::ADDR_BITS];
    res.zero  = (total[ffra_pkg::ADDR_BITS-1:0] == '0);
  end

endmodule

`default_nettype wire

// File: src/first_fit_region_allocator_unit.sv
// first-fit region allocator: sequencer, shared alu, region table ram and output register
// depends on ffra_pkg, ffra_alu, ffra_ram and the assertion macro header
// init or an unknown operation goes from idle straight to the finish state; a zero-byte free
//   passes through S_AR_START and S_AR_RET first; table walks read, then check, each entry
// one item in flight; the next transfer is taken in the cycle after the result is loaded
// reset clears sequencer, count, totals, config and out_valid; table ram is not cleared
`default_nettype none

`include "first_fit_region_allocator_unit_defines.svh"

module first_fit_region_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write port
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [47:0] cfg_data,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [47:0] req_bytes,
  input  wire logic [47:0] block_offset,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      alloc_offset,
  output logic [1:0]       status,
  output logic [47:0]      free_total
);

  localparam int IDX_W = ffra_pkg::IDX_W;
  localparam int CNT_W = ffra_pkg::CNT_W;

  // control state
  ffra_pkg::state_t state, state_next;
  ffra_pkg::cnt_t   cnt, cnt_next;
  ffra_pkg::addr_t  free_r, free_r_next;
  ffra_pkg::addr_t  space_r, space_r_next;
  logic             autogrow;
  ffra_pkg::addr_t  init_bytes;

  // working registers of the current item
  ffra_pkg::ctx_t    ctx, ctx_next;
  logic              grown, grown_next;
  ffra_pkg::addr_t   pos_r, pos_r_next;
  ffra_pkg::addr_t   len_r, len_r_next;
  ffra_pkg::addr_t   req_s, req_s_next;
  ffra_pkg::addr_t   end_r, end_r_next;
  ffra_pkg::cnt_t    idx, idx_next;
  ffra_pkg::cnt_t    slot, slot_next;
  ffra_pkg::addr_t   new_free, new_free_next;
  ffra_pkg::addr_t   new_space, new_space_next;
  ffra_pkg::addr_t   pred_start, pred_start_next;
  ffra_pkg::addr_t   pred_len, pred_len_next;
  ffra_pkg::addr_t   pred_end, pred_end_next;
  logic              has_pred, has_pred_next;
  ffra_pkg::addr_t   succ_start, succ_start_next;
  ffra_pkg::addr_t   succ_len, succ_len_next;
  logic              has_succ, has_succ_next;
  logic              merge_pred, merge_pred_next;
  logic              merge_succ, merge_succ_next;
  ffra_pkg::addr_t   tmp, tmp_next;
  ffra_pkg::addr_t   res_off, res_off_next;
  ffra_pkg::status_t res_st, res_st_next;
  ffra_pkg::status_t ar_st, ar_st_next;

  // output register
  logic              out_valid_next;
  logic [47:0]       alloc_offset_next;
  logic [1:0]        status_next;
  logic [47:0]       free_total_next;

  // shared alu
  ffra_pkg::alu_req_t alu_req;
  ffra_pkg::alu_res_t alu_res;

  // table ram
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  ffra_pkg::region_t     ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [$bits(ffra_pkg::region_t)-1:0] ram_rd_bits;
  ffra_pkg::region_t     rdata;

  ffra_pkg::cnt_t idx_p1, idx_m1, slot_m1;

  assign idx_p1  = idx + CNT_W'(1);
  assign idx_m1  = idx - CNT_W'(1);
  assign slot_m1 = slot - CNT_W'(1);
  assign rdata   = ram_rd_bits;

  ffra_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  ffra_ram #(
    .DEPTH (ffra_pkg::TABLE_DEPTH),
    .WIDTH ($bits(ffra_pkg::region_t))
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rd_bits)
  );

  // only one item at a time: new request taken in idle only
  assign in_stall = (state != ffra_pkg::S_IDLE);

  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    free_r_next       = free_r;
    space_r_next      = space_r;
    ctx_next          = ctx;
    grown_next        = grown;
    pos_r_next        = pos_r;
    len_r_next        = len_r;
    req_s_next        = req_s;
    end_r_next        = end_r;
    idx_next          = idx;
    slot_next         = slot;
    new_free_next     = new_free;
    new_space_next    = new_space;
    pred_start_next   = pred_start;
    pred_len_next     = pred_len;
    pred_end_next     = pred_end;
    has_pred_next     = has_pred;
    succ_start_next   = succ_start;
    succ_len_next     = succ_len;
    has_succ_next     = has_succ;
    merge_pred_next   = merge_pred;
    merge_succ_next   = merge_succ;
    tmp_next          = tmp;
    res_off_next      = res_off;
    res_st_next       = res_st;
    ar_st_next        = ar_st;
    // result leaves on a transfer
    out_valid_next    = out_valid & out_stall;
    alloc_offset_next = alloc_offset;
    status_next       = status;
    free_total_next   = free_total;

    alu_req   = '0;
    ram_we    = 1'b0;
    ram_waddr = idx[IDX_W-1:0];
    ram_wdata = '0;
    ram_raddr = idx[IDX_W-1:0];

    case (state)
      ffra_pkg::S_IDLE: begin
        if (in_valid) begin
          pos_r_next   = block_offset;
          len_r_next   = req_bytes;
          req_s_next   = req_bytes;
          res_off_next = '0;
          res_st_next  = ffra_pkg::ST_OK;
          grown_next   = 1'b0;
          case (operation)
            ffra_pkg::OP_ALLOC: begin
              ctx_next   = ffra_pkg::CTX_ALLOC;
              state_next = ffra_pkg::S_A_START;
            end
            ffra_pkg::OP_FREE: begin
              ctx_next   = ffra_pkg::CTX_FREE;
              state_next = ffra_pkg::S_AR_START;
            end
            ffra_pkg::OP_INIT: begin
              // one region covering the whole initial space, or an empty table
              cnt_next          = (init_bytes != '0) ? CNT_W'(1) : '0;
              ram_we            = (init_bytes != '0);
              ram_waddr         = '0;
              ram_wdata.start   = '0;
              ram_wdata.length  = init_bytes;
              free_r_next       = init_bytes;
              space_r_next      = init_bytes;
              state_next        = ffra_pkg::S_FINISH;
            end
            default: begin
              state_next = ffra_pkg::S_FINISH;
            end
          endcase
        end
      end

      // ---------------- allocate ----------------
      ffra_pkg::S_A_START: begin
        alu_req.a   = free_r;
        alu_req.b   = req_s;
        alu_req.sub = 1'b1;
        if (req_s == '0) begin
          state_next = ffra_pkg::S_Z_RD;
        end else if (!alu_res.carry) begin
          // short of free bytes
          if (!autogrow) begin
            res_st_next = ffra_pkg::ST_NOSPACE;
            state_next  = ffra_pkg::S_FINISH;
          end else begin
            state_next = ffra_pkg::S_GROW_START;
          end
        end else begin
          idx_next   = '0;
          state_next = ffra_pkg::S_FF_RD;
        end
      end

      ffra_pkg::S_GROW_START: begin
        alu_req.a  = space_r;
        alu_req.b  = req_s;
        grown_next = 1'b1;
        if (alu_res.carry) begin
          res_st_next = ffra_pkg::ST_FULL;
          state_next  = ffra_pkg::S_FINISH;
        end else begin
          // growth frees the bytes just past the current end of space
          new_space_next = alu_res.sum;
          pos_r_next     = space_r;
          len_r_next     = req_s;
          ctx_next       = ffra_pkg::CTX_GROW;
          state_next     = ffra_pkg::S_AR_START;
        end
      end

      // ---------------- add region (free or growth) ----------------
      ffra_pkg::S_AR_START: begin
        alu_req.a = pos_r;
        alu_req.b = len_r;
        if (len_r == '0) begin
          ar_st_next = ffra_pkg::ST_OK;
          state_next = ffra_pkg::S_AR_RET;
        end else if (alu_res.carry) begin
          ar_st_next = ffra_pkg::ST_FULL;
          state_next = ffra_pkg::S_AR_RET;
        end else begin
          end_r_next    = alu_res.sum;
          idx_next      = '0;
          has_pred_next = 1'b0;
          state_next    = ffra_pkg::S_AR_RD;
        end
      end

      ffra_pkg::S_AR_RD: begin
        if (idx < cnt) begin
          state_next = ffra_pkg::S_AR_CK;
        end else begin
          has_succ_next = 1'b0;
          slot_next     = idx;
          state_next    = ffra_pkg::S_AR_P1;
        end
      end

      ffra_pkg::S_AR_CK: begin
        // entry starts at or below the new region: it is the predecessor so far
        alu_req.a   = pos_r;
        alu_req.b   = rdata.start;
        alu_req.sub = 1'b1;
        if (alu_res.carry) begin
          pred_start_next = rdata.start;
          pred_len_next   = rdata.length;
          has_pred_next   = 1'b1;
          idx_next        = idx_p1;
          state_next      = ffra_pkg::S_AR_RD;
        end else begin
          succ_start_next = rdata.start;
          succ_len_next   = rdata.length;
          has_succ_next   = 1'b1;
          slot_next       = idx;
          state_next      = ffra_pkg::S_AR_P1;
        end
      end

      ffra_pkg::S_AR_P1: begin
        alu_req.a = pred_start;
        alu_req.b = pred_len;
        if (has_pred) begin
          pred_end_next = alu_res.sum;
          state_next    = ffra_pkg::S_AR_P2;
        end else begin
          merge_pred_next = 1'b0;
          state_next      = ffra_pkg::S_AR_S1;
        end
      end

      ffra_pkg::S_AR_P2: begin
        // start inside the predecessor is a double free
        alu_req.a   = pos_r;
        alu_req.b   = pred_end;
        alu_req.sub = 1'b1;
        if (!alu_res.carry) begin
          ar_st_next = ffra_pkg::ST_DFREE;
          state_next = ffra_pkg::S_AR_RET;
        end else begin
          merge_pred_next = alu_res.zero;
          state_next      = ffra_pkg::S_AR_S1;
        end
      end

      ffra_pkg::S_AR_S1: begin
        // end past the successor start is an overlap
        alu_req.a   = succ_start;
        alu_req.b   = end_r;
        alu_req.sub = 1'b1;
        if (!has_succ) begin
          merge_succ_next = 1'b0;
          state_next      = ffra_pkg::S_AR_F;
        end else if (!alu_res.carry) begin
          ar_st_next = ffra_pkg::ST_DFREE;
          state_next = ffra_pkg::S_AR_RET;
        end else begin
          merge_succ_next = alu_res.zero;
          state_next      = ffra_pkg::S_AR_F;
        end
      end

      ffra_pkg::S_AR_F: begin
        alu_req.a = free_r;
        alu_req.b = len_r;
        if (alu_res.carry) begin
          ar_st_next = ffra_pkg::ST_FULL;
          state_next = ffra_pkg::S_AR_RET;
        end else begin
          new_free_next = alu_res.sum;
          if (merge_pred) begin
            state_next = ffra_pkg::S_AR_MP;
          end else if (merge_succ) begin
            state_next = ffra_pkg::S_AR_MS;
          end else if (cnt >= CNT_W'(ffra_pkg::TABLE_DEPTH)) begin
            ar_st_next = ffra_pkg::ST_FULL;
            state_next = ffra_pkg::S_AR_RET;
          end else begin
            idx_next   = cnt;
            state_next = ffra_pkg::S_INS_RD;
          end
        end
      end

      ffra_pkg::S_AR_MP: begin
        alu_req.a = pred_len;
        alu_req.b = len_r;
        tmp_next  = alu_res.sum;
        if (merge_succ) begin
          state_next = ffra_pkg::S_AR_MB;
        end else begin
          ram_we           = 1'b1;
          ram_waddr        = slot_m1[IDX_W-1:0];
          ram_wdata.start  = pred_start;
          ram_wdata.length = alu_res.sum;
          state_next       = ffra_pkg::S_AR_OK;
        end
      end

      ffra_pkg::S_AR_MB: begin
        // predecessor absorbs the region and the successor, then the gap closes
        alu_req.a        = tmp;
        alu_req.b        = succ_len;
        ram_we           = 1'b1;
        ram_waddr        = slot_m1[IDX_W-1:0];
        ram_wdata.start  = pred_start;
        ram_wdata.length = alu_res.sum;
        idx_next         = slot;
        state_next       = ffra_pkg::S_DROP_RD;
      end

      ffra_pkg::S_AR_MS: begin
        alu_req.a        = succ_len;
        alu_req.b        = len_r;
        ram_we           = 1'b1;
        ram_waddr        = slot[IDX_W-1:0];
        ram_wdata.start  = pos_r;
        ram_wdata.length = alu_res.sum;
        state_next       = ffra_pkg::S_AR_OK;
      end

      // open a slot by moving entries up, top first
      ffra_pkg::S_INS_RD: begin
        ram_raddr = idx_m1[IDX_W-1:0];
        if (idx > slot) begin
          state_next = ffra_pkg::S_INS_WR;
        end else begin
          ram_we           = 1'b1;
          ram_waddr        = slot[IDX_W-1:0];
          ram_wdata.start  = pos_r;
          ram_wdata.length = len_r;
          cnt_next         = cnt + CNT_W'(1);
          state_next       = ffra_pkg::S_AR_OK;
        end
      end

      ffra_pkg::S_INS_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = rdata;
        idx_next   = idx_m1;
        state_next = ffra_pkg::S_INS_RD;
      end

      // close the gap at idx by moving entries down
      ffra_pkg::S_DROP_RD: begin
        ram_raddr = idx_p1[IDX_W-1:0];
        if (idx_p1 < cnt) begin
          state_next = ffra_pkg::S_DROP_WR;
        end else begin
          cnt_next = cnt - CNT_W'(1);
          if (ctx == ffra_pkg::CTX_ALLOC) begin
            state_next = ffra_pkg::S_A_FREE;
          end else begin
            state_next = ffra_pkg::S_AR_OK;
          end
        end
      end

      ffra_pkg::S_DROP_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = rdata;
        idx_next   = idx_p1;
        state_next = ffra_pkg::S_DROP_RD;
      end

      ffra_pkg::S_AR_OK: begin
        free_r_next = new_free;
        ar_st_next  = ffra_pkg::ST_OK;
        state_next  = ffra_pkg::S_AR_RET;
      end

      ffra_pkg::S_AR_RET: begin
        if (ctx == ffra_pkg::CTX_GROW && ar_st == ffra_pkg::ST_OK) begin
          space_r_next = new_space;
          ctx_next     = ffra_pkg::CTX_ALLOC;
          idx_next     = '0;
          state_next   = ffra_pkg::S_FF_RD;
        end else begin
          res_st_next = ar_st;
          state_next  = ffra_pkg::S_FINISH;
        end
      end

      // ---------------- first-fit search ----------------
      ffra_pkg::S_FF_RD: begin
        if (idx < cnt) begin
          state_next = ffra_pkg::S_FF_CK;
        end else if (!grown) begin
          state_next = ffra_pkg::S_GROW_START;
        end else begin
          res_st_next = ffra_pkg::ST_NOSPACE;
          state_next  = ffra_pkg::S_FINISH;
        end
      end

      ffra_pkg::S_FF_CK: begin
        alu_req.a   = rdata.length;
        alu_req.b   = req_s;
        alu_req.sub = 1'b1;
        if (!alu_res.carry) begin
          idx_next   = idx_p1;
          state_next = ffra_pkg::S_FF_RD;
        end else begin
          res_off_next    = rdata.start;
          succ_start_next = rdata.start;
          succ_len_next   = rdata.length;
          // exact fit removes the entry, otherwise keep the remainder
          state_next = alu_res.zero ? ffra_pkg::S_DROP_RD : ffra_pkg::S_FF_SP1;
        end
      end

      ffra_pkg::S_FF_SP1: begin
        alu_req.a  = succ_start;
        alu_req.b  = req_s;
        tmp_next   = alu_res.sum;
        state_next = ffra_pkg::S_FF_SP2;
      end

      ffra_pkg::S_FF_SP2: begin
        alu_req.a        = succ_len;
        alu_req.b        = req_s;
        alu_req.sub      = 1'b1;
        ram_we           = 1'b1;
        ram_wdata.start  = tmp;
        ram_wdata.length = alu_res.sum;
        state_next       = ffra_pkg::S_A_FREE;
      end

      ffra_pkg::S_A_FREE: begin
        // free total floors at zero
        alu_req.a   = free_r;
        alu_req.b   = req_s;
        alu_req.sub = 1'b1;
        free_r_next = alu_res.carry ? alu_res.sum : '0;
        res_st_next = ffra_pkg::ST_OK;
        state_next  = ffra_pkg::S_FINISH;
      end

      // zero-byte allocate answers the lowest free start
      ffra_pkg::S_Z_RD: begin
        ram_raddr  = '0;
        state_next = (cnt != '0) ? ffra_pkg::S_Z_CK : ffra_pkg::S_FINISH;
      end

      ffra_pkg::S_Z_CK: begin
        res_off_next = rdata.start;
        state_next   = ffra_pkg::S_FINISH;
      end

      ffra_pkg::S_FINISH: begin
        // wait for the output register to be free
        if (!out_valid || !out_stall) begin
          out_valid_next    = 1'b1;
          alloc_offset_next = res_off;
          status_next       = res_st;
          free_total_next   = free_r;
          state_next        = ffra_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ffra_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ffra_pkg::S_IDLE;
      cnt        <= '0;
      free_r     <= '0;
      space_r    <= '0;
      out_valid  <= 1'b0;
      autogrow   <= 1'b0;
      init_bytes <= '0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      free_r    <= free_r_next;
      space_r   <= space_r_next;
      out_valid <= out_valid_next;
      if (cfg_write) begin
        case (cfg_index)
          ffra_pkg::CFG_AUTOGROW:   autogrow   <= cfg_data[0];
          ffra_pkg::CFG_INIT_BYTES: init_bytes <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    ctx          <= ctx_next;
    grown        <= grown_next;
    pos_r        <= pos_r_next;
    len_r        <= len_r_next;
    req_s        <= req_s_next;
    end_r        <= end_r_next;
    idx          <= idx_next;
    slot         <= slot_next;
    new_free     <= new_free_next;
    new_space    <= new_space_next;
    pred_start   <= pred_start_next;
    pred_len     <= pred_len_next;
    pred_end     <= pred_end_next;
    has_pred     <= has_pred_next;
    succ_start   <= succ_start_next;
    succ_len     <= succ_len_next;
    has_succ     <= has_succ_next;
    merge_pred   <= merge_pred_next;
    merge_succ   <= merge_succ_next;
    tmp          <= tmp_next;
    res_off      <= res_off_next;
    res_st       <= res_st_next;
    ar_st        <= ar_st_next;
    alloc_offset <= alloc_offset_next;
    status       <= status_next;
    free_total   <= free_total_next;
  end

  // region count never passes the table size
  `FFRA_ASSERT_ALWAYS(a_cnt_bound, cnt <= CNT_W'(ffra_pkg::TABLE_DEPTH))
  // any failed operation reports a zero offset
  `FFRA_ASSERT_IMPL(a_fail_zero_off, out_valid && status != ffra_pkg::ST_OK, alloc_offset == '0)
  // an accepted request always starts the sequencer
  `FFRA_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state != ffra_pkg::S_IDLE)

endmodule

`default_nettype wire
